FILE: hw/rtl/mcfe_pkg.sv
// ---------------------------------------------------------------------------
// mcfe_pkg: shared types and constants for the command frame encoder
// Opcodes, status codes, frame bytes and the descriptor passed from the
// classifier to the byte sequencer.
// ---------------------------------------------------------------------------
package mcfe_pkg;

    localparam int MAX_BYTES = 6;

    // Opcodes
    localparam logic [4:0] OP_CLEAR    = 5'd0;
    localparam logic [4:0] OP_BLOCK    = 5'd1;
    localparam logic [4:0] OP_LINEAR   = 5'd2;
    localparam logic [4:0] OP_CIRCULAR = 5'd3;
    localparam logic [4:0] OP_PLOT     = 5'd4;
    localparam logic [4:0] OP_2D       = 5'd5;
    localparam logic [4:0] OP_FONT     = 5'd6;
    localparam logic [4:0] OP_X        = 5'd7;
    localparam logic [4:0] OP_Y        = 5'd8;
    localparam logic [4:0] OP_ANGLE    = 5'd9;
    localparam logic [4:0] OP_SPACING  = 5'd10;
    localparam logic [4:0] OP_HEIGHT   = 5'd11;
    localparam logic [4:0] OP_NEXT     = 5'd12;
    localparam logic [4:0] OP_RESET    = 5'd13;
    localparam logic [4:0] OP_START    = 5'd14;
    localparam logic [4:0] OP_STOP     = 5'd15;
    localparam logic [4:0] OP_QUERY    = 5'd16;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    // Operand limits
    localparam logic [9:0] MAX_BLOCK   = 10'd99;
    localparam logic [9:0] MAX_FONT    = 10'd7;
    localparam logic [9:0] MAX_NUMERIC = 10'd999;
    localparam logic [9:0] MAX_QUERY   = 10'd14;

    // Frame bytes
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_CAN  = 8'h18;
    localparam logic [7:0] CH_TERM = ";";
    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_AT   = "@";
    localparam logic [7:0] CH_B    = "B";
    localparam logic [7:0] CH_G    = "G";
    localparam logic [7:0] CH_1    = "1";
    localparam logic [7:0] CH_2    = "2";
    localparam logic [7:0] CH_3    = "3";
    localparam logic [7:0] CH_5    = "5";
    localparam logic [7:0] CH_H    = "H";
    localparam logic [7:0] CH_I    = "I";
    localparam logic [7:0] CH_J    = "J";
    localparam logic [7:0] CH_L    = "L";
    localparam logic [7:0] CH_M    = "M";
    localparam logic [7:0] CH_O    = "O";
    localparam logic [7:0] CH_Z    = "Z";
    localparam logic [7:0] CH_PCT  = "%";
    localparam logic [7:0] CH_BANG = "!";
    localparam logic [7:0] CH_QM   = "?";

    // Decoded frame: bytes in send order, count 1..6, status
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                len;
        logic [1:0]                status;
    } frame_t;

    // Query field letter for index 0..14
    function automatic logic [7:0] query_code(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "G";
            4'd1:    c = "H";
            4'd2:    c = "I";
            4'd3:    c = "J";
            4'd4:    c = "K";
            4'd5:    c = "L";
            4'd6:    c = "M";
            4'd7:    c = "O";
            4'd8:    c = "Q";
            4'd9:    c = "P";
            4'd10:   c = "R";
            4'd11:   c = "S";
            4'd12:   c = "U";
            4'd13:   c = "$";
            default: c = "#";
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/mcfe_front.sv
// ---------------------------------------------------------------------------
// mcfe_front: command classifier
// Checks opcode and operand, splits the operand into decimal digits and
// builds the full frame descriptor for the queue.
// ---------------------------------------------------------------------------
module mcfe_front (
    input  logic [4:0]      opcode,
    input  logic [9:0]      operand_value,
    output mcfe_pkg::frame_t frame
);
    import mcfe_pkg::*;

    logic [15:0] hund_prod;
    logic [3:0]  hund;
    logic [6:0]  rem100;
    logic [13:0] tens_prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic [7:0]  num_letter;

    // Decimal split by reciprocal multiply; exact for operands up to 999
    always_comb
    begin
        hund_prod = 16'(operand_value) * 16'd41;
        hund      = hund_prod[15:12];
        rem100    = 7'(operand_value - 10'(hund) * 10'd100);
        tens_prod = 14'(rem100) * 14'd103;
        tens      = tens_prod[13:10];
        ones      = 4'(rem100 - 7'(tens) * 7'd10);
    end

    // Letter of the numeric commands
    always_comb
    begin
        case (opcode)
            OP_X:       num_letter = CH_I;
            OP_Y:       num_letter = CH_J;
            OP_ANGLE:   num_letter = CH_L;
            OP_SPACING: num_letter = CH_M;
            default:    num_letter = CH_O;
        endcase
    end

    // Frame assembly
    always_comb
    begin
        frame          = '0;
        frame.status   = ST_OK;
        frame.bytes[0] = CH_ESC;
        unique case (opcode)
            OP_CLEAR:
            begin
                frame.bytes[1] = CH_AT;
                frame.bytes[2] = CH_TERM;
                frame.len      = 3'd3;
            end
            OP_BLOCK:
            begin
                frame.bytes[1] = CH_B;
                frame.bytes[2] = CH_ZERO + 8'(tens);
                frame.bytes[3] = CH_ZERO + 8'(ones);
                frame.bytes[4] = CH_TERM;
                frame.len      = 3'd5;
            end
            OP_LINEAR, OP_CIRCULAR, OP_PLOT, OP_2D:
            begin
                frame.bytes[1] = CH_G;
                frame.bytes[2] = (opcode == OP_LINEAR)   ? CH_1 :
                                 (opcode == OP_CIRCULAR) ? CH_2 :
                                 (opcode == OP_PLOT)     ? CH_3 : CH_5;
                frame.bytes[3] = CH_TERM;
                frame.len      = 3'd4;
            end
            OP_FONT:
            begin
                frame.bytes[1] = CH_H;
                frame.bytes[2] = CH_ZERO + 8'(operand_value[2:0]);
                frame.bytes[3] = CH_TERM;
                frame.len      = 3'd4;
            end
            OP_X, OP_Y, OP_ANGLE, OP_SPACING, OP_HEIGHT:
            begin
                frame.bytes[1] = num_letter;
                frame.bytes[2] = CH_ZERO + 8'(hund);
                frame.bytes[3] = CH_ZERO + 8'(tens);
                frame.bytes[4] = CH_ZERO + 8'(ones);
                frame.bytes[5] = CH_TERM;
                frame.len      = 3'd6;
            end
            OP_NEXT, OP_RESET, OP_START:
            begin
                frame.bytes[1] = (opcode == OP_NEXT)  ? CH_Z :
                                 (opcode == OP_RESET) ? CH_PCT : CH_BANG;
                frame.bytes[2] = CH_TERM;
                frame.len      = 3'd3;
            end
            OP_STOP:
            begin
                frame.bytes[0] = CH_CAN;
                frame.len      = 3'd1;
            end
            OP_QUERY:
            begin
                frame.bytes[1] = CH_QM;
                frame.bytes[2] = query_code(operand_value[3:0]);
                frame.bytes[3] = CH_TERM;
                frame.len      = 3'd4;
            end
            default:
            begin
                frame.bytes[0] = '0;
                frame.len      = 3'd1;
                frame.status   = ST_UNKNOWN;
            end
        endcase

        // Operand range errors replace the frame by one error transaction
        if (((opcode == OP_BLOCK) && (operand_value > MAX_BLOCK)) ||
            ((opcode == OP_FONT) && (operand_value > MAX_FONT)) ||
            ((opcode >= OP_X) && (opcode <= OP_HEIGHT) && (operand_value > MAX_NUMERIC)) ||
            ((opcode == OP_QUERY) && (operand_value > MAX_QUERY)))
        begin
            frame        = '0;
            frame.len    = 3'd1;
            frame.status = ST_RANGE;
        end
    end

endmodule

FILE: hw/rtl/mcfe_queue.sv
// ---------------------------------------------------------------------------
// mcfe_queue: descriptor queue
// Small register queue that decouples the classifier from the sequencer.
// ---------------------------------------------------------------------------
module mcfe_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  mcfe_pkg::frame_t wr_data,
    output logic             full,
    input  logic             rd_en,
    output mcfe_pkg::frame_t rd_data,
    output logic             rd_valid
);
    import mcfe_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_t             entry_reg [DEPTH];
    logic [IDX_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hw/rtl/mcfe_back.sv
// ---------------------------------------------------------------------------
// mcfe_back: byte sequencer
// Walks the bytes of the current frame into a registered output stage,
// one byte per cycle while the consumer keeps up.
// ---------------------------------------------------------------------------
module mcfe_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mcfe_pkg::frame_t q_data,
    input  logic             q_valid,
    output logic             q_take,
    output logic [7:0]       frame_byte,
    output logic             last_byte,
    output logic [1:0]       status,
    output logic             empty,
    input  logic             pop
);
    import mcfe_pkg::*;

    frame_t      cur_reg;
    logic        cur_valid_reg, cur_valid_next;
    logic [2:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [1:0]  status_reg;
    logic        load;
    logic        cur_last;

    assign cur_last = ((idx_reg + 3'd1) == cur_reg.len);
    assign load     = cur_valid_reg && (!out_valid_reg || pop);
    assign q_take   = q_valid && (!cur_valid_reg || (load && cur_last));

    assign frame_byte = byte_reg;
    assign last_byte  = last_reg;
    assign status     = status_reg;
    assign empty      = !out_valid_reg;

    // Sequencer control
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 3'd1;
            if (cur_last)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (q_take)
        begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            cur_reg <= q_data;
        end
        if (load)
        begin
            byte_reg   <= cur_reg.bytes[idx_reg];
            last_reg   <= cur_last;
            status_reg <= cur_reg.status;
        end
    end

endmodule

FILE: hw/rtl/marking_command_frame_encoder_core.sv
// ---------------------------------------------------------------------------
// marking_command_frame_encoder_core: serial command frame encoder
// Turns opcode/operand commands into framed bytes for a marking unit.
// ---------------------------------------------------------------------------
// Each command transaction yields one to six byte transactions: ESC, body,
// ';' (stop is a lone CAN byte; a bad operand or unknown opcode gives a
// single zero byte with a nonzero status and last_byte set). Commands are
// classified in the cycle they are pushed and held in a QUEUE_DEPTH-entry
// queue; the byte sequencer then sends one byte per cycle while pop keeps
// up, so a command occupies the output for as many byte transactions as its
// frame has bytes (1 to 6). A pushed command passes from the queue entry to
// the sequencer's frame register, then its first byte to the output register.
// push is taken whenever the queue has room, independent of the output side.
module marking_command_frame_encoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [4:0] opcode,
    input  logic [9:0] operand_value,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] frame_byte,
    output logic       last_byte,
    output logic [1:0] status
);
    import mcfe_pkg::*;

    frame_t in_frame;
    frame_t q_data;
    logic   q_valid;
    logic   q_take;

    mcfe_front u_front (
        .opcode        (opcode),
        .operand_value (operand_value),
        .frame         (in_frame)
    );

    mcfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (in_frame),
        .full     (full),
        .rd_en    (q_take),
        .rd_data  (q_data),
        .rd_valid (q_valid)
    );

    mcfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (q_data),
        .q_valid    (q_valid),
        .q_take     (q_take),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .status     (status),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

FILE: hw/rtl/mcfe_checker.sv
// ---------------------------------------------------------------------------
// mcfe_checker: port-level checks for the frame encoder
// Watches the result side of the top level and flags malformed output.
// ---------------------------------------------------------------------------
module mcfe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] frame_byte,
    input logic       last_byte,
    input logic [1:0] status
);
    import mcfe_pkg::*;

    // Error transactions are single zero bytes
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status != ST_OK)) |-> (last_byte && (frame_byte == '0)))
        else $error("error transaction is not a single zero byte");

    // Only the final byte of a frame may carry a status
    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last_byte) |-> (status == ST_OK))
        else $error("status set on a non-final byte");

    // A good frame ends in ';' or is the stop byte
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_byte && (status == ST_OK)) |->
        ((frame_byte == CH_TERM) || (frame_byte == CH_CAN)))
        else $error("frame ends in an unexpected byte");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
        (!empty && $stable(frame_byte) && $stable(last_byte) && $stable(status)))
        else $error("stalled result changed");

endmodule

bind marking_command_frame_encoder_core mcfe_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .status     (status)
);

FILE: bench/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for marking_command_frame_encoder_core
// Feeds command transactions through a queue-style input, predicts each
// frame byte locally and checks every byte transaction on the output side.
// ---------------------------------------------------------------------------
// A directed batch covers every opcode, the operand limits on both sides and
// unknown opcodes. Random commands follow in three idle mixes (sender busy /
// receiver lazy, the reverse, then neither idle). A long output hold-off in
// the last mix fills the block and stalls its input.
module tb;
    import mcfe_pkg::*;

    // Operand limits and query letters, kept independent of the RTL
    localparam logic [9:0]        BLOCK_LIMIT   = 10'd99;
    localparam logic [9:0]        FONT_LIMIT    = 10'd7;
    localparam logic [9:0]        NUMERIC_LIMIT = 10'd999;
    localparam logic [9:0]        QUERY_LIMIT   = 10'd14;
    localparam logic [8*15-1:0]   QUERY_LETTERS = "GHIJKLMOQPRSU$#";

    localparam int RANDOM_PER_PHASE = 102;
    localparam int HOLD_CYCLES      = 120;
    localparam int STALL_LIMIT      = 1000;
    localparam int TAIL_CYCLES      = 10;

    typedef struct {
        logic [4:0] opcode;
        logic [9:0] operand;
    } cmd_t;

    typedef struct {
        logic [7:0] frame_byte;
        logic       last;
        logic [1:0] status;
    } frame_result_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       push          = 1'b0;
    logic       pop           = 1'b0;
    logic [4:0] opcode        = 5'd0;
    logic [9:0] operand_value = 10'd0;
    logic       full;
    logic       empty;
    logic [7:0] frame_byte;
    logic       last_byte;
    logic [1:0] status;

    cmd_t          pending_cmds   [$];
    frame_result_t expected_bytes [$];

    int unsigned send_idle_pct   = 0;
    int unsigned recv_idle_pct   = 0;
    logic        hold_off_request = 1'b0;
    logic        hold_off_started = 1'b0;
    int          hold_left        = 0;

    int mismatches    = 0;
    int cmds_accepted = 0;
    int bytes_checked = 0;
    int error_results = 0;
    int full_stalls   = 0;
    int quiet_cycles  = 0;

    marking_command_frame_encoder_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .operand_value (operand_value),
        .empty         (empty),
        .pop           (pop),
        .frame_byte    (frame_byte),
        .last_byte     (last_byte),
        .status        (status)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected bytes of one command's frame
    function automatic void predict_frame(input cmd_t c);
        logic [7:0] frame [$];
        logic [1:0] err;
        err = ST_OK;
        if (c.opcode == OP_STOP)
            frame.push_back(CH_CAN);
        else if (c.opcode > OP_QUERY)
            err = ST_UNKNOWN;
        else
        begin
            frame.push_back(CH_ESC);
            case (c.opcode)
                OP_CLEAR:    frame.push_back(CH_AT);
                OP_BLOCK:
                begin
                    if (c.operand > BLOCK_LIMIT)
                        err = ST_RANGE;
                    frame.push_back(CH_B);
                    frame.push_back(CH_ZERO + 8'(c.operand / 10));
                    frame.push_back(CH_ZERO + 8'(c.operand % 10));
                end
                OP_LINEAR:   begin frame.push_back(CH_G); frame.push_back(CH_1); end
                OP_CIRCULAR: begin frame.push_back(CH_G); frame.push_back(CH_2); end
                OP_PLOT:     begin frame.push_back(CH_G); frame.push_back(CH_3); end
                OP_2D:       begin frame.push_back(CH_G); frame.push_back(CH_5); end
                OP_FONT:
                begin
                    if (c.operand > FONT_LIMIT)
                        err = ST_RANGE;
                    frame.push_back(CH_H);
                    frame.push_back(CH_ZERO + 8'(c.operand));
                end
                OP_X, OP_Y, OP_ANGLE, OP_SPACING, OP_HEIGHT:
                begin
                    if (c.operand > NUMERIC_LIMIT)
                        err = ST_RANGE;
                    case (c.opcode)
                        OP_X:       frame.push_back(CH_I);
                        OP_Y:       frame.push_back(CH_J);
                        OP_ANGLE:   frame.push_back(CH_L);
                        OP_SPACING: frame.push_back(CH_M);
                        default:    frame.push_back(CH_O);
                    endcase
                    frame.push_back(CH_ZERO + 8'(c.operand / 100));
                    frame.push_back(CH_ZERO + 8'((c.operand / 10) % 10));
                    frame.push_back(CH_ZERO + 8'(c.operand % 10));
                end
                OP_NEXT:     frame.push_back(CH_Z);
                OP_RESET:    frame.push_back(CH_PCT);
                OP_START:    frame.push_back(CH_BANG);
                OP_QUERY:
                begin
                    if (c.operand > QUERY_LIMIT)
                        err = ST_RANGE;
                    else
                    begin
                        frame.push_back(CH_QM);
                        frame.push_back(QUERY_LETTERS[8*(14 - c.operand[3:0]) +: 8]);
                    end
                end
                default: ;
            endcase
            frame.push_back(CH_TERM);
        end

        if (err != ST_OK)
        begin
            error_results++;
            expected_bytes.push_back('{8'h00, 1'b1, err});
        end
        else
            foreach (frame[k])
                expected_bytes.push_back('{frame[k], k == frame.size() - 1, ST_OK});
    endfunction

    // Mostly well-formed commands, some with any opcode or operand
    function automatic cmd_t random_command();
        cmd_t        c;
        int unsigned pick;
        logic [9:0]  limit;
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            c.opcode  = 5'($urandom_range(31));
            c.operand = 10'($urandom_range(1023));
        end
        else
        begin
            c.opcode = 5'($urandom_range(16));
            case (c.opcode)
                OP_BLOCK:                                    limit = BLOCK_LIMIT;
                OP_FONT:                                     limit = FONT_LIMIT;
                OP_X, OP_Y, OP_ANGLE, OP_SPACING, OP_HEIGHT: limit = NUMERIC_LIMIT;
                OP_QUERY:                                    limit = QUERY_LIMIT;
                default:                                     limit = 10'd1023;
            endcase
            if (pick < 30)
                c.operand = 10'($urandom_range(1023));
            else
                c.operand = 10'($urandom_range(limit));
        end
        return c;
    endfunction

    task automatic queue_cmd(input logic [4:0] op, input logic [9:0] val);
        pending_cmds.push_back('{op, val});
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            pending_cmds.push_back(random_command());
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_bytes.size() != 0 || push)
            @(posedge clk);
    endtask

    task automatic check_field(input string field_name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, field_name, want, got);
        end
    endtask

    // Driver: offer the oldest pending command, hold it while full
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                predict_frame('{opcode, operand_value});
                void'(pending_cmds.pop_front());
                cmds_accepted++;
            end
            if (push && full)
                full_stalls++;
            if (pending_cmds.size() != 0 &&
                ((push && full) || $urandom_range(99) >= send_idle_pct))
            begin
                push          <= 1'b1;
                opcode        <= pending_cmds[0].opcode;
                operand_value <= pending_cmds[0].operand;
            end
            else
                push <= 1'b0;
        end
    end

    // Monitor: check each byte transaction, then pick the next pop
    always @(posedge clk)
    begin : monitor
        frame_result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected byte: expected none, actual 0x%0h last %0b status %0d",
                             $time, frame_byte, last_byte, status);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    check_field("frame_byte", want.frame_byte, frame_byte);
                    check_field("last_byte", 8'(want.last), 8'(last_byte));
                    check_field("status", 8'(want.status), 8'(status));
                    bytes_checked++;
                end
            end

            // long hold-off, once, when requested
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                pop       <= 1'b0;
            end
            else if (hold_off_request && !hold_off_started)
            begin
                hold_off_started <= 1'b1;
                hold_left        <= HOLD_CYCLES;
                pop              <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Stimulus and phases
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 1: sender idles a little, receiver often
        send_idle_pct = 23;
        recv_idle_pct = 50;
        queue_cmd(OP_CLEAR,    10'd1023);
        queue_cmd(OP_BLOCK,    10'd0);
        queue_cmd(OP_BLOCK,    10'd99);
        queue_cmd(OP_BLOCK,    10'd100);
        queue_cmd(OP_LINEAR,   10'd0);
        queue_cmd(OP_CIRCULAR, 10'd511);
        queue_cmd(OP_PLOT,     10'd0);
        queue_cmd(OP_2D,       10'd1023);
        queue_cmd(OP_FONT,     10'd0);
        queue_cmd(OP_FONT,     10'd7);
        queue_cmd(OP_FONT,     10'd8);
        queue_cmd(OP_X,        10'd0);
        queue_cmd(OP_Y,        10'd999);
        queue_cmd(OP_ANGLE,    10'd1000);
        queue_cmd(OP_SPACING,  10'd1023);
        queue_cmd(OP_HEIGHT,   10'd505);
        queue_cmd(OP_NEXT,     10'd0);
        queue_cmd(OP_RESET,    10'd682);
        queue_cmd(OP_START,    10'd341);
        queue_cmd(OP_STOP,     10'd1023);
        queue_cmd(OP_QUERY,    10'd0);
        queue_cmd(OP_QUERY,    10'd14);
        queue_cmd(OP_QUERY,    10'd15);
        queue_cmd(5'd17,       10'd0);
        queue_cmd(5'd31,       10'd1023);
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        // phase 2: the reverse
        send_idle_pct = 50;
        recv_idle_pct = 23;
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        // phase 3: no idling, with one long output hold-off
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        hold_off_request = 1'b1;
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d commands, %0d byte transactions (%0d error results)",
                 cmds_accepted, bytes_checked, error_results);
        $display("Three idle mixes, one output hold-off; input held by full for %0d cycles",
                 full_stalls);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
